// ===== hw/rtl/sha_npc_pkg.sv =====
// Package for the nonce prefix checker: SHA-256 constants, round and
// message schedule functions, and the binary to BCD conversion step.
// No dependencies.
`default_nettype none

package sha_npc_pkg;

	localparam int unsigned MAX_PREFIX_NIBBLES = 16;
	localparam int unsigned DIGITS = 20;
	localparam int unsigned BCD_W = 4 * DIGITS;
	localparam int unsigned DD_STAGES = 8;
	localparam int unsigned DD_BITS = 64 / DD_STAGES;
	localparam int unsigned ROUNDS = 64;

	localparam logic [1:0] REG_PREFIX_VALUE = 2'd0;
	localparam logic [1:0] REG_PREFIX_NIBBLES = 2'd1;

	typedef logic [7:0][31:0] sha_state_t;
	typedef logic [15:0][31:0] sha_window_t;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Index 7 is a, index 0 is h.
	localparam sha_state_t INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [55:0] FIXED_TEXT = 56'h62_69_74_63_6f_69_6e;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
		return (x >> r) | (x << (32 - r));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// One SHA-256 round on state s with schedule word w.
	function automatic sha_state_t sha_round(input sha_state_t s, input logic [31:0] k,
			input logic [31:0] w);
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		a = s[7]; b = s[6]; c = s[5]; d = s[4];
		e = s[3]; f = s[2]; g = s[1]; h = s[0];
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k + w;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		return {t1 + t2, a, b, c, d + t1, e, f, g};
	endfunction

	// Slides the schedule window by one word, appending the next word.
	function automatic sha_window_t sched_next(input sha_window_t w);
		logic [31:0] nw;
		nw = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
		return {nw, w[15:1]};
	endfunction

	// Shift-and-add-3 conversion of DD_BITS input bits, MSB first.
	function automatic logic [BCD_W-1:0] dd_steps(input logic [BCD_W-1:0] bcd_in,
			input logic [DD_BITS-1:0] bits);
		logic [BCD_W-1:0] bcd;
		logic [3:0] dg;
		bcd = bcd_in;
		for (int s = DD_BITS - 1; s >= 0; s--) begin
			for (int d = 0; d < DIGITS; d++) begin
				dg = bcd[4*d +: 4];
				if (dg >= 4'd5) begin
					bcd[4*d +: 4] = dg + 4'd3;
				end
			end
			bcd = {bcd[BCD_W-2:0], bits[s]};
		end
		return bcd;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha256_nonce_prefix_check.sv =====
// Top level of the SHA-256 nonce prefix checker: a fully pipelined hash
// engine with decimal conversion in front and prefix compare behind.
// Depends on sha_npc_pkg.
`default_nettype none

// Usage.
// A host drives a candidate on nonce and raises start; the beat is taken at
// any rising edge where start is high and busy is low. busy is always low,
// so a new nonce can be given in every cycle.
// Each nonce gives one result beat: done is high for exactly one cycle while
// nonce_out, matched and digest_w0..digest_w3 hold the result. Results come
// out in the order the nonces went in.
// The stages are 8 of decimal conversion (8 bits per stage), one that finds
// the digit count, one that builds the padded block, 64 round stages (one
// SHA-256 round and one schedule word each), one that adds the initial hash
// and one output stage that does the prefix compare.
// Throughput is one nonce per cycle; the 64 round stages set the depth.
// The receiver cannot stall, so the pipeline advances every cycle.
// The configuration port (cfg_we, cfg_index, cfg_data) writes prefix_value
// (index 0) or prefix_nibbles (index 1); other indexes are ignored. Write it
// only while no nonce is in flight. The prefix is read at the output stage.
// Reset clears both registers and all valid bits; data in flight is dropped.
module sha256_nonce_prefix_check
	import sha_npc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [63:0] nonce,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output      logic        done,
	output      logic [63:0] nonce_out,
	output      logic        matched,
	output      logic [63:0] digest_w0,
	output      logic [63:0] digest_w1,
	output      logic [63:0] digest_w2,
	output      logic [63:0] digest_w3
);

	localparam int unsigned NIB_CAP = (MAX_PREFIX_NIBBLES < 16) ? MAX_PREFIX_NIBBLES : 16;

	logic [63:0] prefix_value_q;
	logic [4:0]  prefix_nibbles_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_value_q   <= '0;
			prefix_nibbles_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PREFIX_VALUE:   prefix_value_q <= cfg_data;
				REG_PREFIX_NIBBLES: prefix_nibbles_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Decimal conversion: each stage consumes the next 8 bits of the nonce.
	logic             dd_v_s     [1:DD_STAGES];
	logic [BCD_W-1:0] dd_bcd_s   [1:DD_STAGES];
	logic [63:0]      dd_bin_s   [1:DD_STAGES];
	logic [63:0]      dd_nonce_s [1:DD_STAGES];

	for (genvar k = 1; k <= DD_STAGES; k++) begin : g_dd
		if (k == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) dd_v_s[k] <= 1'b0;
				else dd_v_s[k] <= accept;
			end
			always_ff @(posedge clk) begin
				dd_bcd_s[k]   <= dd_steps('0, nonce[63 -: DD_BITS]);
				dd_bin_s[k]   <= nonce << DD_BITS;
				dd_nonce_s[k] <= nonce;
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) dd_v_s[k] <= 1'b0;
				else dd_v_s[k] <= dd_v_s[k-1];
			end
			always_ff @(posedge clk) begin
				dd_bcd_s[k]   <= dd_steps(dd_bcd_s[k-1], dd_bin_s[k-1][63 -: DD_BITS]);
				dd_bin_s[k]   <= dd_bin_s[k-1] << DD_BITS;
				dd_nonce_s[k] <= dd_nonce_s[k-1];
			end
		end
	end

	// Digit count: position of the most significant nonzero digit, at least 1.
	logic [4:0] nd_c;
	always_comb begin
		nd_c = 5'd1;
		for (int i = 0; i < DIGITS; i++) begin
			if (dd_bcd_s[DD_STAGES][4*i +: 4] != 4'd0) begin
				nd_c = 5'(i + 1);
			end
		end
	end

	logic             len_v_s;
	logic [BCD_W-1:0] len_bcd_s;
	logic [4:0]       len_nd_s;
	logic [63:0]      len_nonce_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_v_s <= 1'b0;
		else len_v_s <= dd_v_s[DD_STAGES];
	end
	always_ff @(posedge clk) begin
		len_bcd_s   <= dd_bcd_s[DD_STAGES];
		len_nd_s    <= nd_c;
		len_nonce_s <= dd_nonce_s[DD_STAGES];
	end

	// Padded block: the text, the digits as ASCII, the 0x80 marker and the
	// bit length in the last bytes.
	logic [6:0]       shamt_c;
	logic [BCD_W-1:0] bcd_al_c;
	logic [511:0]     blk_c;
	logic [7:0]       bitlen_c;
	always_comb begin
		shamt_c  = 7'(({2'b00, 5'(DIGITS)} - {2'b00, len_nd_s}) << 2);
		bcd_al_c = len_bcd_s << shamt_c;
		bitlen_c = 8'(({3'b000, len_nd_s} + 8'd7) << 3);
		blk_c    = '0;
		blk_c[511 -: 56] = FIXED_TEXT;
		for (int j = 0; j <= DIGITS; j++) begin
			if (j < DIGITS && 5'(j) < len_nd_s) begin
				blk_c[511 - 8*(7+j) -: 8] = {4'h3, bcd_al_c[BCD_W - 1 - 4*j -: 4]};
			end else if (5'(j) == len_nd_s) begin
				blk_c[511 - 8*(7+j) -: 8] = 8'h80;
			end
		end
		blk_c[7:0] = bitlen_c;
	end

	logic        blk_v_s;
	sha_window_t blk_w_s;
	logic [63:0] blk_nonce_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) blk_v_s <= 1'b0;
		else blk_v_s <= len_v_s;
	end
	always_ff @(posedge clk) begin
		for (int j = 0; j < 16; j++) begin
			blk_w_s[j] <= blk_c[511 - 32*j -: 32];
		end
		blk_nonce_s <= len_nonce_s;
	end

	// Round stages: stage r+1 holds the state after round r. The window's
	// oldest word is the schedule word for the round.
	logic        rnd_v_s   [1:ROUNDS];
	sha_state_t  rnd_st_s  [1:ROUNDS];
	sha_window_t rnd_w_s   [1:ROUNDS-1];
	logic [63:0] rnd_n_s   [1:ROUNDS];

	for (genvar r = 0; r < ROUNDS; r++) begin : g_rnd
		if (r == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) rnd_v_s[1] <= 1'b0;
				else rnd_v_s[1] <= blk_v_s;
			end
			always_ff @(posedge clk) begin
				rnd_st_s[1] <= sha_round(INIT_H, ROUND_K[0], blk_w_s[0]);
				rnd_w_s[1]  <= sched_next(blk_w_s);
				rnd_n_s[1]  <= blk_nonce_s;
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) rnd_v_s[r+1] <= 1'b0;
				else rnd_v_s[r+1] <= rnd_v_s[r];
			end
			always_ff @(posedge clk) begin
				rnd_st_s[r+1] <= sha_round(rnd_st_s[r], ROUND_K[r], rnd_w_s[r][0]);
				rnd_n_s[r+1]  <= rnd_n_s[r];
			end
			if (r < ROUNDS - 1) begin : g_win
				always_ff @(posedge clk) begin
					rnd_w_s[r+1] <= sched_next(rnd_w_s[r]);
				end
			end
		end
	end

	// Final addition of the initial hash values.
	logic        fin_v_s;
	sha_state_t  fin_h_s;
	logic [63:0] fin_n_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_v_s <= 1'b0;
		else fin_v_s <= rnd_v_s[ROUNDS];
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			fin_h_s[i] <= rnd_st_s[ROUNDS][i] + INIT_H[i];
		end
		fin_n_s <= rnd_n_s[ROUNDS];
	end

	// Prefix compare over the leading nibbles of the first digest word.
	logic [4:0]  nsat_c;
	logic [63:0] dw0_c;
	logic        match_c;
	always_comb begin
		nsat_c = (prefix_nibbles_q > 5'(NIB_CAP)) ? 5'(NIB_CAP) : prefix_nibbles_q;
		dw0_c  = {fin_h_s[7], fin_h_s[6]};
		match_c = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < nsat_c && dw0_c[63 - 4*i -: 4] != prefix_value_q[63 - 4*i -: 4]) begin
				match_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= fin_v_s;
	end
	always_ff @(posedge clk) begin
		nonce_out <= fin_n_s;
		matched   <= match_c;
		digest_w0 <= dw0_c;
		digest_w1 <= {fin_h_s[5], fin_h_s[4]};
		digest_w2 <= {fin_h_s[3], fin_h_s[2]};
		digest_w3 <= {fin_h_s[1], fin_h_s[0]};
	end

	// Every accepted nonce is taken as a result once it has passed every stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##76 done)
		else $error("result missing 76 cycles after accept");

	// The final add stage feeds the output stage in lock step.
	a_fin_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v_s |=> done)
		else $error("final stage beat lost before output");

	// A zero nibble count always matches.
	a_zero_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && prefix_nibbles_q == 5'd0) |-> matched)
		else $error("zero prefix length did not match");

endmodule

`default_nettype wire

// ===== bench/tb_sha256_nonce_prefix_check.sv =====
// Testbench for sha256_nonce_prefix_check: drives candidate nonces and prefix settings,
// predicts each digest and match flag with its own SHA-256 and checks every result beat.
// Depends on sha_npc_pkg and the sha256_nonce_prefix_check RTL.
`default_nettype none

module tb_sha256_nonce_prefix_check;
	import sha_npc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	// Pipeline depth given at the head of the block, with some margin.
	localparam int unsigned DRAIN_CYCLES = 100;

	typedef struct {
		logic [63:0]  nonce;
		logic         matched;
		logic [255:0] digest;
	} hash_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] nonce;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        done;
	logic [63:0] nonce_out;
	logic        matched;
	logic [63:0] digest_w0, digest_w1, digest_w2, digest_w3;

	// Private copy of the two prefix registers, updated on every write.
	logic [63:0] model_prefix;
	logic [4:0]  model_nibbles;

	hash_result_t pending_hashes[$];
	int unsigned  mismatches;
	int unsigned  cycle_count;
	int unsigned  gap_percent;

	sha256_nonce_prefix_check i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.nonce     (nonce),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.nonce_out (nonce_out),
		.matched   (matched),
		.digest_w0 (digest_w0),
		.digest_w1 (digest_w1),
		.digest_w2 (digest_w2),
		.digest_w3 (digest_w3)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// SHA-256 round constants, kept separate from the design's own table so
	// that an error there shows up as a digest mismatch.
	localparam logic [31:0] HASH_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int r);
		return (x >> r) | (x << (32 - r));
	endfunction

	// Digest of "bitcoin" followed by the decimal digits of the candidate.
	// The message never exceeds 27 bytes, so one padded block is enough.
	function automatic logic [255:0] hash_candidate(input logic [63:0] cand);
		logic [7:0]  msg [64];
		logic [7:0]  digits [20];
		logic [31:0] w [64];
		logic [31:0] hv [8];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		logic [63:0] rest, bit_len;
		logic [55:0] text;
		int          nd, len;
		rest = cand;
		nd = 0;
		text = 56'h62_69_74_63_6f_69_6e;
		do begin
			digits[nd] = 8'h30 + 8'(rest % 64'd10);
			rest = rest / 64'd10;
			nd++;
		end while (rest != 64'd0);
		for (int i = 0; i < 64; i++) msg[i] = 8'h00;
		for (int i = 0; i < 7; i++) msg[i] = text[55 - 8 * i -: 8];
		len = 7;
		for (int i = 0; i < nd; i++) begin
			msg[len] = digits[nd - 1 - i];
			len++;
		end
		msg[len] = 8'h80;
		bit_len = 64'(len) * 64'd8;
		for (int i = 0; i < 8; i++) msg[63 - i] = bit_len[8 * i +: 8];
		for (int i = 0; i < 16; i++)
			w[i] = {msg[4 * i], msg[4 * i + 1], msg[4 * i + 2], msg[4 * i + 3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = w[i - 16] + s0 + w[i - 7] + s1;
		end
		hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; hh = hv[7];
		for (int i = 0; i < 64; i++) begin
			t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ HASH_K[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			hh = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		return {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d,
			hv[4] + e, hv[5] + f, hv[6] + g, hv[7] + hh};
	endfunction

	// The compare covers the leading nibbles of the digest's top word. The
	// count saturates at 16, and a count of zero always matches.
	function automatic logic prefix_hit(input logic [63:0] top_word);
		int n;
		int sh;
		n = (model_nibbles > 5'd16) ? 16 : int'(model_nibbles);
		if (n == 0) begin
			return 1'b1;
		end
		sh = 64 - 4 * n;
		return (top_word >> sh) == (model_prefix >> sh);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Drives one nonce and waits for the edge that accepts it. start stays
	// high when the next beat follows directly, so it is never lowered and
	// raised in the same step.
	task automatic send_nonce(input logic [63:0] cand);
		hash_result_t exp_hash;
		start <= 1'b1;
		nonce <= cand;
		do @(posedge clk); while (busy);
		exp_hash.nonce = cand;
		exp_hash.digest = hash_candidate(cand);
		exp_hash.matched = prefix_hit(exp_hash.digest[255:192]);
		pending_hashes.push_back(exp_hash);
		if (gap_percent != 0 && $urandom_range(99, 0) < gap_percent) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Stops sending and waits for every outstanding result to arrive.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0) @(posedge clk);
	endtask

	// Register writes happen only while nothing is in flight.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PREFIX_VALUE) begin
			model_prefix = value;
		end else if (idx == REG_PREFIX_NIBBLES) begin
			model_nibbles = value[4:0];
		end
		@(posedge clk);
	endtask

	// Random candidates of every decimal length: a full 64-bit value shifted
	// right by a random amount reaches every digit count and every bit.
	function automatic logic [63:0] random_nonce();
		return {$urandom(), $urandom()} >> $urandom_range(63, 0);
	endfunction

	// Digit count edges: zero, one digit, powers of ten and their neighbours,
	// the top bit alone, the largest value (20 digits) and alternating bits.
	task automatic test_digit_lengths();
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'd0);
		gap_percent = 0;
		send_nonce(64'd0);
		send_nonce(64'd9);
		send_nonce(64'd10);
		send_nonce(64'd99);
		send_nonce(64'd100);
		send_nonce(64'd999999999);
		send_nonce(64'd1000000000);
		send_nonce(64'd9999999999999999999);
		send_nonce(64'd10000000000000000000);
		send_nonce(64'h8000_0000_0000_0000);
		send_nonce(64'hFFFF_FFFF_FFFF_FFFF);
		send_nonce(64'h5555_5555_5555_5555);
		send_nonce(64'hAAAA_AAAA_AAAA_AAAA);
	endtask

	// Prefix rules: a full 16-nibble match, counts above 16 that must saturate,
	// a miss in the last nibble only, a 15-nibble match and a one-nibble compare.
	task automatic test_prefix_rules();
		logic [255:0] full_digest;
		logic [63:0]  top;
		full_digest = hash_candidate(64'd12345);
		top = full_digest[255:192];
		drain_results();
		write_reg(REG_PREFIX_VALUE, top);
		write_reg(REG_PREFIX_NIBBLES, 64'd16);
		send_nonce(64'd12345);
		send_nonce(64'd12346);
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'd31);
		send_nonce(64'd12345);
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'd17);
		write_reg(REG_PREFIX_VALUE, top ^ 64'h1);
		send_nonce(64'd12345);
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'd15);
		send_nonce(64'd12345);
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'd1);
		write_reg(REG_PREFIX_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_nonce(64'd12345);
		send_nonce(64'd7);
	endtask

	// Writes to unused indexes must leave both registers untouched; the
	// data carries all ones so a stray write would show.
	task automatic test_unused_index();
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'd2);
		write_reg(REG_PREFIX_VALUE, 64'd0);
		write_reg(2'd2, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
		send_nonce(64'd42);
		send_nonce(64'd43);
	endtask

	// One random phase: new settings while idle, then a run of candidates
	// with the given percent chance of an idle gap after each one. Short
	// prefixes keep matches frequent; a few prefixes are taken from the
	// digest of an upcoming nonce so that long compares match too.
	task automatic test_random_phase(input int unsigned pct, input int unsigned count);
		logic [63:0]  cand;
		logic [255:0] cand_digest;
		logic [4:0]   cnt;
		cand = random_nonce();
		cand_digest = hash_candidate(cand);
		cnt = 5'($urandom_range(4, 0));
		if ($urandom_range(3, 0) == 0) begin
			cnt = 5'($urandom_range(31, 5));
		end
		drain_results();
		write_reg(REG_PREFIX_NIBBLES, 64'(cnt));
		if ($urandom_range(1, 0) == 0) begin
			write_reg(REG_PREFIX_VALUE, cand_digest[255:192]);
		end else begin
			write_reg(REG_PREFIX_VALUE, {$urandom(), $urandom()});
		end
		gap_percent = pct;
		send_nonce(cand);
		for (int i = 1; i < count; i++) begin
			send_nonce(random_nonce());
		end
		gap_percent = 0;
	endtask

	// Result checker: each done beat is taken at the edge ending its cycle
	// and compared with the oldest prediction.
	always @(posedge clk) begin
		hash_result_t exp_hash;
		if (arst_n && done) begin
			if (pending_hashes.size() == 0) begin
				report_mismatch($sformatf("unexpected result for nonce %0d", nonce_out));
			end else begin
				exp_hash = pending_hashes.pop_front();
				if (nonce_out !== exp_hash.nonce) begin
					report_mismatch($sformatf("nonce_out %h, expected %h",
						nonce_out, exp_hash.nonce));
				end
				if (matched !== exp_hash.matched) begin
					report_mismatch($sformatf("matched %b, expected %b for nonce %0d",
						matched, exp_hash.matched, exp_hash.nonce));
				end
				if (digest_w0 !== exp_hash.digest[255:192]) begin
					report_mismatch($sformatf("digest_w0 %h, expected %h",
						digest_w0, exp_hash.digest[255:192]));
				end
				if (digest_w1 !== exp_hash.digest[191:128]) begin
					report_mismatch($sformatf("digest_w1 %h, expected %h",
						digest_w1, exp_hash.digest[191:128]));
				end
				if (digest_w2 !== exp_hash.digest[127:64]) begin
					report_mismatch($sformatf("digest_w2 %h, expected %h",
						digest_w2, exp_hash.digest[127:64]));
				end
				if (digest_w3 !== exp_hash.digest[63:0]) begin
					report_mismatch($sformatf("digest_w3 %h, expected %h",
						digest_w3, exp_hash.digest[63:0]));
				end
			end
		end
	end

	// Watchdog: a hung pipeline ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sha256_nonce_prefix_check verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		nonce = 64'd0;
		cfg_we = 1'b0;
		cfg_index = REG_PREFIX_VALUE;
		cfg_data = 64'd0;
		cycle_count = 0;
		mismatches = 0;
		gap_percent = 0;
		model_prefix = 64'd0;
		model_nibbles = 5'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first beat runs on reset values, which give zero nibbles.
		send_nonce(64'd1);
		test_digit_lengths();
		test_prefix_rules();
		test_unused_index();
		// Phases: back to back, sender mostly idle, back to back again
		// (the receiver cannot stall), then light idling.
		for (int p = 0; p < 4; p++) begin
			test_random_phase(0, 70);
			test_random_phase(64, 40);
			test_random_phase(0, 30);
			test_random_phase(16, 10);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("sha256_nonce_prefix_check verification clean");
		end else begin
			$display("sha256_nonce_prefix_check verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sha256_nonce_prefix_check.f =====
hw/rtl/sha_npc_pkg.sv
hw/rtl/sha256_nonce_prefix_check.sv
bench/tb_sha256_nonce_prefix_check.sv
